[hdl/bsa_pkg.sv]
// shared types, status codes and default sizes for the bitmap slot allocator
package bsa_pkg;

   // default sizes
   localparam int SLOTS_DEFAULT        = 256;
   localparam int WORD_BITS_DEFAULT    = 64;
   localparam int PAYLOAD_BITS_DEFAULT = 32;

   // fixed port widths
   localparam int OP_W      = 1;
   localparam int IN_PAY_W  = 32;
   localparam int ID_W      = 8;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_ACQUIRE = 1'b0;
   localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_BUSY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clear;      // clearing pass writes one bitmap word
      logic load;       // transfer accepted, capture request
      logic scan;       // issue next bitmap read, check previous word
      logic grant;      // mark slot busy and store payload
      logic rel_read;   // read bitmap word and payload of release id
      logic rel_check;  // decide release outcome and write back
   } bsa_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic clr_last;   // clearing pass is at the last word
      logic chk_valid;  // a bitmap word is ready to be checked
      logic found;      // checked word holds a free slot
      logic chk_last;   // checked word is the last word
   } bsa_stat_type;

endpackage

[hdl/bitmap_slot_allocator_unit.sv]
// top level of the bitmap slot allocator
// Hands out the lowest free slot (slot 0 is reserved) and takes slots back,
// storing one payload per busy slot. A request transfers when start is high
// and busy is low; the result appears for exactly one cycle with rsp_valid
// and cannot be held off, so capture it when the strobe is seen. The busy
// bitmap sits in a RAM read one word per cycle: an acquire checks the words
// from word 0 upward until one holds a free slot, and reports the pool full
// if the last word has none. The bitmap has NWORDS = ceil(SLOTS/WORD_BITS)
// words (4 at the default size). A release reads the bitmap word and payload
// of its id, then decides the outcome and writes back. The strobe is high in
// the first cycle with busy low. After reset a clearing pass initializes the
// bitmap, and busy stays high until it is done.
module bitmap_slot_allocator_unit #(
   parameter int SLOTS        = bsa_pkg::SLOTS_DEFAULT,
   parameter int WORD_BITS    = bsa_pkg::WORD_BITS_DEFAULT,
   parameter int PAYLOAD_BITS = bsa_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bsa_pkg::OP_W-1:0]      req_op,
   input  logic [bsa_pkg::IN_PAY_W-1:0]  req_new_payload,
   input  logic [bsa_pkg::ID_W-1:0]      req_release_slot,
   output logic                          rsp_valid,
   output logic [bsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bsa_pkg::ID_W-1:0]      rsp_granted_slot,
   output logic [bsa_pkg::IN_PAY_W-1:0]  rsp_returned_payload,
   output logic [bsa_pkg::COUNT_W-1:0]   rsp_busy_count
);

   bsa_pkg::bsa_cmd_type  cmd;
   bsa_pkg::bsa_stat_type stat;

   // sequencing
   bsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_op),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // storage and search
   bsa_dpath #(
      .SLOTS        (SLOTS),
      .WORD_BITS    (WORD_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_new_payload      (req_new_payload),
      .req_release_slot     (req_release_slot),
      .rsp_status           (rsp_status),
      .rsp_granted_slot     (rsp_granted_slot),
      .rsp_returned_payload (rsp_returned_payload),
      .rsp_busy_count       (rsp_busy_count)
   );

endmodule

[hdl/bsa_ram.sv]
// generic simple dual port ram with registered read
module bsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bsa_ctrl.sv]
// sequencing state machine of the bitmap slot allocator
module bsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [0:0]           req_op,
   input  bsa_pkg::bsa_stat_type stat,
   output bsa_pkg::bsa_cmd_type  cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_SCAN     = 3'd2;
   localparam logic [2:0] ST_GRANT    = 3'd3;
   localparam logic [2:0] ST_REL_RD   = 3'd4;
   localparam logic [2:0] ST_REL_CHK  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       scan_full;

   // commands decoded from the state
   always_comb begin
      cmd           = '0;
      cmd.clear     = (state_ff == ST_CLEAR);
      cmd.load      = (state_ff == ST_IDLE) && start;
      cmd.scan      = (state_ff == ST_SCAN);
      cmd.grant     = (state_ff == ST_GRANT);
      cmd.rel_read  = (state_ff == ST_REL_RD);
      cmd.rel_check = (state_ff == ST_REL_CHK);
   end

   assign scan_full = (state_ff == ST_SCAN) && stat.chk_valid && !stat.found && stat.chk_last;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = (req_op == bsa_pkg::OP_RELEASE) ? ST_REL_RD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.chk_valid && stat.found) begin
               state_in = ST_GRANT;
            end else if (scan_full) begin
               state_in = ST_IDLE;
            end
         end
         ST_GRANT:   state_in = ST_IDLE;
         ST_REL_RD:  state_in = ST_REL_CHK;
         ST_REL_CHK: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // result strobe follows the deciding cycle
   assign rsp_valid_in = scan_full || (state_ff == ST_GRANT) || (state_ff == ST_REL_CHK);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // an accepted transfer always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not start work");

   // one strobe per item, never back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   // a result is only shown once the work is done
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe while still working");

endmodule

[hdl/bsa_dpath.sv]
// bitmap, payload store, search and counters of the bitmap slot allocator
module bsa_dpath #(
   parameter int SLOTS        = bsa_pkg::SLOTS_DEFAULT,
   parameter int WORD_BITS    = bsa_pkg::WORD_BITS_DEFAULT,
   parameter int PAYLOAD_BITS = bsa_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bsa_pkg::bsa_cmd_type            cmd,
   output bsa_pkg::bsa_stat_type           stat,
   input  logic [bsa_pkg::IN_PAY_W-1:0]    req_new_payload,
   input  logic [bsa_pkg::ID_W-1:0]        req_release_slot,
   output logic [bsa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bsa_pkg::ID_W-1:0]        rsp_granted_slot,
   output logic [bsa_pkg::IN_PAY_W-1:0]    rsp_returned_payload,
   output logic [bsa_pkg::COUNT_W-1:0]     rsp_busy_count
);

   localparam int NWords   = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW       = (NWords > 1) ? $clog2(NWords) : 1;
   localparam int SW       = $clog2(SLOTS);
   localparam int BW       = $clog2(WORD_BITS);
   localparam int CalcW    = SW + 1;
   localparam int LastBits = SLOTS - (NWords - 1) * WORD_BITS;
   localparam logic [WORD_BITS-1:0] LastMask =
      {WORD_BITS{1'b1}} >> (WORD_BITS - LastBits);
   // reciprocal for id / WORD_BITS, exact for 8-bit ids
   localparam int RecipK   = 24;
   localparam int RecipW   = 23;
   localparam logic [RecipW-1:0] Recip =
      RecipW'(((1 << RecipK) + WORD_BITS - 1) / WORD_BITS);

   // request capture
   logic [PAYLOAD_BITS-1:0]        payload_ff;
   logic [bsa_pkg::ID_W-1:0]       id_ff;
   logic [AW-1:0]                  rel_word_ff;
   logic [BW-1:0]                  rel_bit_ff;
   logic                           rel_invalid_ff;

   // scan and clear control
   logic [AW-1:0]                  scan_ff;
   logic [AW-1:0]                  chk_ff;
   logic                           chk_valid_ff;
   logic [AW-1:0]                  clr_ff;

   // grant holding
   logic [WORD_BITS-1:0]           grant_word_ff;
   logic [SW-1:0]                  slot_ff;

   // results
   logic [bsa_pkg::STATUS_W-1:0]   status_ff;
   logic [bsa_pkg::ID_W-1:0]       granted_ff;
   logic [bsa_pkg::IN_PAY_W-1:0]   returned_ff;
   logic [bsa_pkg::COUNT_W-1:0]    count_ff;

   // ram ports
   logic                           bm_wr_en;
   logic [AW-1:0]                  bm_wr_addr;
   logic [WORD_BITS-1:0]           bm_wr_data;
   logic [AW-1:0]                  bm_rd_addr;
   logic [WORD_BITS-1:0]           bm_rd_data;
   logic [SW-1:0]                  pay_rd_addr;
   logic [PAYLOAD_BITS-1:0]        pay_rd_data;

   // search and divide helpers
   logic [WORD_BITS-1:0]           word_mask;
   logic [WORD_BITS-1:0]           free_bits;
   logic [WORD_BITS-1:0]           low_free;
   logic [BW-1:0]                  free_idx;
   logic [CalcW-1:0]               slot_calc;
   logic [bsa_pkg::ID_W+RecipW-1:0] rel_prod;
   logic [bsa_pkg::ID_W-1:0]       rel_q;
   logic [2*bsa_pkg::ID_W-1:0]     rel_qw;
   logic [bsa_pkg::ID_W-1:0]       rel_rem;
   logic                           rel_bit_busy;
   logic                           rel_ok;
   logic                           scan_full;

   // lowest free bit of the checked word, unused tail bits read busy
   assign word_mask = (chk_ff == AW'(NWords - 1)) ? LastMask : {WORD_BITS{1'b1}};
   assign free_bits = ~bm_rd_data & word_mask;
   assign low_free  = free_bits & (~free_bits + WORD_BITS'(1));

   always_comb begin
      free_idx = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (low_free[b]) begin
            free_idx = free_idx | BW'(b);
         end
      end
   end

   assign slot_calc = CalcW'(chk_ff) * CalcW'(WORD_BITS) + CalcW'(free_idx);

   // word and bit of the release id
   assign rel_prod = (bsa_pkg::ID_W + RecipW)'(req_release_slot) *
                     (bsa_pkg::ID_W + RecipW)'(Recip);
   assign rel_q    = rel_prod[RecipK +: bsa_pkg::ID_W];
   assign rel_qw   = rel_q * (2*bsa_pkg::ID_W)'(WORD_BITS);
   assign rel_rem  = req_release_slot - rel_qw[bsa_pkg::ID_W-1:0];

   assign rel_bit_busy = bm_rd_data[rel_bit_ff];
   assign rel_ok       = !rel_invalid_ff && rel_bit_busy;
   assign scan_full    = cmd.scan && chk_valid_ff && !(|free_bits) &&
                         (chk_ff == AW'(NWords - 1));

   // status to the controller
   always_comb begin
      stat           = '0;
      stat.clr_last  = (clr_ff == AW'(NWords - 1));
      stat.chk_valid = chk_valid_ff;
      stat.found     = |free_bits;
      stat.chk_last  = (chk_ff == AW'(NWords - 1));
   end

   // bitmap port selection
   always_comb begin
      bm_wr_en   = cmd.clear || cmd.grant || (cmd.rel_check && rel_ok);
      bm_wr_addr = rel_word_ff;
      bm_wr_data = bm_rd_data & ~(WORD_BITS'(1) << rel_bit_ff);
      if (cmd.clear) begin
         bm_wr_addr = clr_ff;
         bm_wr_data = (clr_ff == '0) ? WORD_BITS'(1) : '0;
      end else if (cmd.grant) begin
         bm_wr_addr = chk_ff;
         bm_wr_data = grant_word_ff;
      end
   end

   assign bm_rd_addr  = cmd.rel_read ? rel_word_ff : scan_ff;
   assign pay_rd_addr = SW'(id_ff);

   bsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NWords)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   bsa_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (SLOTS)
   ) u_payload (
      .clock   (clock),
      .wr_en   (cmd.grant),
      .wr_addr (slot_ff),
      .wr_data (payload_ff),
      .rd_addr (pay_rd_addr),
      .rd_data (pay_rd_data)
   );

   // request capture on accepted transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         payload_ff     <= PAYLOAD_BITS'(req_new_payload);
         id_ff          <= req_release_slot;
         rel_word_ff    <= AW'(rel_q);
         rel_bit_ff     <= BW'(rel_rem);
         rel_invalid_ff <= (req_release_slot == '0) ||
                           (32'(req_release_slot) >= 32'(SLOTS));
      end
   end

   // scan and clear counters, the checked word stays put once it has a free slot
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         scan_ff      <= '0;
         chk_ff       <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.load) begin
            scan_ff      <= '0;
            chk_valid_ff <= 1'b0;
         end else if (cmd.scan) begin
            scan_ff      <= scan_ff + AW'(1);
            chk_valid_ff <= 1'b1;
            if (!(chk_valid_ff && (|free_bits))) begin
               chk_ff <= scan_ff;
            end
         end
      end
   end

   // hold the found slot for the grant cycle
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         grant_word_ff <= bm_rd_data | low_free;
         slot_ff       <= SW'(slot_calc);
      end
   end

   // allocation count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.grant) begin
         count_ff <= count_ff + bsa_pkg::COUNT_W'(1);
      end else if (cmd.rel_check && rel_ok) begin
         count_ff <= count_ff - bsa_pkg::COUNT_W'(1);
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (scan_full) begin
         status_ff   <= bsa_pkg::STATUS_FULL;
         granted_ff  <= '0;
         returned_ff <= '0;
      end else if (cmd.grant) begin
         status_ff   <= bsa_pkg::STATUS_OK;
         granted_ff  <= bsa_pkg::ID_W'(slot_ff);
         returned_ff <= '0;
      end else if (cmd.rel_check) begin
         granted_ff  <= '0;
         returned_ff <= '0;
         if (rel_invalid_ff) begin
            status_ff <= bsa_pkg::STATUS_INVALID;
         end else if (!rel_bit_busy) begin
            status_ff <= bsa_pkg::STATUS_NOT_BUSY;
         end else begin
            status_ff   <= bsa_pkg::STATUS_OK;
            returned_ff <= bsa_pkg::IN_PAY_W'(pay_rd_data);
         end
      end
   end

   assign rsp_status           = status_ff;
   assign rsp_granted_slot     = granted_ff;
   assign rsp_returned_payload = returned_ff;
   assign rsp_busy_count       = count_ff;

endmodule
